### design/lpht_pkg.sv
// Package for the linear probing hash table: widths, codes and the tdata layout.
// Used by the top level, lpht_front and lpht_back; depends on nothing.
package lpht_pkg;
	localparam int Slots = 1024;
	localparam int SlotW = $clog2(Slots);
	localparam int CountW = 11;
	localparam int QueueDepth = 4;
	localparam int QueueW = $clog2(QueueDepth);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] MM_REPLACE = 2'd0;
	localparam logic [1:0] MM_ADD = 2'd1;

	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_LIVE = 2'd1;
	localparam logic [1:0] ST_TOMB = 2'd2;

	localparam logic [2:0] RS_INSERTED = 3'd0;
	localparam logic [2:0] RS_MERGED = 3'd1;
	localparam logic [2:0] RS_FOUND = 3'd2;
	localparam logic [2:0] RS_NOT_FOUND = 3'd3;
	localparam logic [2:0] RS_REMOVED = 3'd4;
	localparam logic [2:0] RS_FULL = 3'd5;

	localparam logic CFG_MERGE_MODE = 1'b0;
	localparam logic CFG_ENTRY_LIMIT = 1'b1;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic [1:0] op;
		logic [31:0] key;
		logic [31:0] value;
		logic [SlotW-1:0] home;
	} req_t;

	// Home slot: non-negative key modulo the slot count (a power of two).
	function automatic logic [SlotW-1:0] home_slot(input logic [31:0] key);
		home_slot = key[SlotW-1:0];
	endfunction
endpackage

### design/linear_probe_hash_table.sv
// Top level of the linear probing hash table: 1024 slots of signed 32-bit keys and values.
// Requests arrive as s_axis transfers, tdata holding operation, key and value from bit 0 up.
// Results leave as m_axis transfers, tdata holding status, result_value and live_count
// from bit 0 up; exactly one result transfer follows each request, in order.
// Config: cfg_we writes cfg_data to register cfg_index (0 merge_mode, 1 entry_limit),
// and must be written only while no request is in flight; the block itself does not enforce this.
// The back end reads one slot at a time, in a read state and then a check state, through
// single-port key, value and flag memories; each further slot probed adds another read
// and check. One request is worked at a time: the back end takes no new request from
// the queue until the result of the last one has been taken.
// A four-entry queue takes requests while the back end works or a result waits.
// Reset clears the live count and the queue and sets merge_mode 0 and entry_limit 768;
// a clearing pass over all 1024 slots then marks every slot empty before the first request
// starts. When the receiver stalls the result is held and the back end waits; the
// queue keeps taking requests until full.
module linear_probe_hash_table (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [71:0] s_axis_tdata, // operation[1:0], key[33:2], value[65:34]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // status[2:0], result_value[34:3], live_count[45:35]
	input logic cfg_we,
	input logic cfg_index,
	input logic [10:0] cfg_data
);
	logic [1:0] merge_mode_q;
	logic [10:0] entry_limit_q;
	logic q_valid, q_pop;
	lpht_pkg::req_t q_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_mode_q <= 2'd0;
			entry_limit_q <= 11'd768;
		end else if (cfg_we) begin
			if (cfg_index == lpht_pkg::CFG_MERGE_MODE) merge_mode_q <= cfg_data[1:0];
			else entry_limit_q <= cfg_data;
		end
	end

	lpht_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[65:0]), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head));

	lpht_back u_back (
		.clk(clk), .arst_n(arst_n), .merge_mode(merge_mode_q), .entry_limit(entry_limit_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_data(m_axis_tdata));
endmodule

### design/lpht_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module lpht_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Read before write, one port: during a write rdata takes the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### design/lpht_front.sv
// Front end: takes request transfers, computes the home slot and queues them.
// Depends on lpht_pkg.
module lpht_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [65:0] in_data,
	output logic q_valid,
	input logic q_pop,
	output lpht_pkg::req_t q_head
);
	lpht_pkg::req_t fifo_q [lpht_pkg::QueueDepth];
	logic [lpht_pkg::QueueW-1:0] wr_q, rd_q;
	logic [lpht_pkg::QueueW:0] cnt_q;
	logic push;
	lpht_pkg::req_t req;

	assign in_ready = (cnt_q != lpht_pkg::QueueW'(0) + (lpht_pkg::QueueW+1)'(lpht_pkg::QueueDepth));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_head = fifo_q[rd_q];

	// Classify the transfer.
	always_comb begin
		req.op = in_data[1:0];
		req.key = in_data[33:2];
		req.value = in_data[65:34];
		req.home = lpht_pkg::home_slot(in_data[33:2]);
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= req;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (lpht_pkg::QueueW+1)'(push) - (lpht_pkg::QueueW+1)'(q_pop);
		end
	end
endmodule

### design/lpht_back.sv
// Back end: probes the slot memories one slot at a time and applies requests.
// Depends on lpht_pkg and lpht_ram.
module lpht_back (
	input logic clk,
	input logic arst_n,
	input logic [1:0] merge_mode,
	input logic [10:0] entry_limit,
	input logic q_valid,
	output logic q_pop,
	input lpht_pkg::req_t q_head,
	output logic out_valid,
	input logic out_ready,
	output logic [47:0] out_data
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;
	lpht_pkg::req_t req_q;
	logic [lpht_pkg::SlotW-1:0] idx_q, free_q, clr_q;
	logic [lpht_pkg::SlotW:0] n_q;
	logic have_free_q;
	logic [10:0] count_q;
	logic [2:0] status_q;
	logic [31:0] rv_q;
	logic out_valid_q;

	logic ram_we_k, ram_we_v, ram_we_f;
	logic [lpht_pkg::SlotW-1:0] addr, target;
	logic [31:0] wkey, wval, rkey, rval;
	logic [1:0] wflag, rflag;
	logic done_probe, hit, absent, fill;

	lpht_ram #(.Width(32), .Depth(lpht_pkg::Slots)) u_keys (
		.clk(clk), .we(ram_we_k), .addr(addr), .wdata(wkey), .rdata(rkey));
	lpht_ram #(.Width(32), .Depth(lpht_pkg::Slots)) u_vals (
		.clk(clk), .we(ram_we_v), .addr(addr), .wdata(wval), .rdata(rval));
	lpht_ram #(.Width(2), .Depth(lpht_pkg::Slots)) u_flags (
		.clk(clk), .we(ram_we_f), .addr(addr), .wdata(wflag), .rdata(rflag));

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_data = {2'd0, count_q, rv_q, status_q};

	// Classification of the slot read in S_CHECK.
	assign done_probe = (n_q == (lpht_pkg::SlotW+1)'(lpht_pkg::Slots));
	assign hit = !done_probe && (rflag == lpht_pkg::ST_LIVE) && (rkey == req_q.key);
	assign absent = done_probe || (rflag == lpht_pkg::ST_EMPTY);
	assign target = have_free_q ? free_q : idx_q;
	assign fill = (state_q == S_CHECK) && absent && (req_q.op == lpht_pkg::OP_INSERT)
		&& (count_q < entry_limit) && (!done_probe || have_free_q);

	// Memory port control: clearing pass, tombstone, merge and fill writes.
	always_comb begin
		ram_we_k = 1'b0;
		ram_we_v = 1'b0;
		ram_we_f = 1'b0;
		addr = idx_q;
		wkey = req_q.key;
		wval = req_q.value;
		wflag = lpht_pkg::ST_LIVE;
		if (state_q == S_CLEAR) begin
			ram_we_f = 1'b1;
			addr = clr_q;
			wflag = lpht_pkg::ST_EMPTY;
		end else if (state_q == S_CHECK) begin
			if (hit && req_q.op == lpht_pkg::OP_REMOVE) begin
				ram_we_f = 1'b1;
				wflag = lpht_pkg::ST_TOMB;
			end else if (hit && req_q.op == lpht_pkg::OP_INSERT) begin
				// Merge modes 2 and 3 write the old value back.
				ram_we_v = 1'b1;
				unique case (merge_mode)
					lpht_pkg::MM_REPLACE: wval = req_q.value;
					lpht_pkg::MM_ADD: wval = rval + req_q.value;
					default: wval = rval;
				endcase
			end else if (fill) begin
				addr = target;
				ram_we_k = 1'b1;
				ram_we_v = 1'b1;
				ram_we_f = 1'b1;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						req_q <= q_head;
						idx_q <= q_head.home;
						n_q <= '0;
						have_free_q <= 1'b0;
						free_q <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (hit) begin
						// Key present.
						if (req_q.op == lpht_pkg::OP_REMOVE) begin
							if (count_q != '0) count_q <= count_q - 11'd1;
							status_q <= lpht_pkg::RS_REMOVED;
							rv_q <= rval;
						end else if (req_q.op == lpht_pkg::OP_INSERT) begin
							status_q <= lpht_pkg::RS_MERGED;
							rv_q <= wval;
						end else begin
							status_q <= lpht_pkg::RS_FOUND;
							rv_q <= rval;
						end
						state_q <= S_OUT;
						out_valid_q <= 1'b1;
					end else if (!absent) begin
						// Keep probing past a live slot or a tombstone.
						if (rflag == lpht_pkg::ST_TOMB && !have_free_q) begin
							have_free_q <= 1'b1;
							free_q <= idx_q;
						end
						idx_q <= idx_q + 1'b1;
						n_q <= n_q + 1'b1;
						state_q <= S_READ;
					end else begin
						// Absent: empty slot or probe limit.
						state_q <= S_OUT;
						out_valid_q <= 1'b1;
						if (req_q.op == lpht_pkg::OP_INSERT) begin
							if (fill) begin
								// The fill writes go in through the memory port this cycle.
								count_q <= count_q + 11'd1;
								status_q <= lpht_pkg::RS_INSERTED;
								rv_q <= req_q.value;
							end else begin
								status_q <= lpht_pkg::RS_FULL;
								rv_q <= '1;
							end
						end else begin
							status_q <= lpht_pkg::RS_NOT_FOUND;
							rv_q <= '1;
						end
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
